/* rtl/pft_pkg.sv */
// ----------------------------------------------------------------------------
// pft_pkg
// Shared constants and helpers for the two-link planar forward kinematics
// pipeline: CORDIC gain and arctangent table, register indexes, saturation.
// ----------------------------------------------------------------------------
`default_nettype none

package pft_pkg;

    localparam int LEN_W    = 15;
    localparam int ANG_W    = 16;
    localparam int COORD_W  = 16;
    localparam int CORDIC_W = 34;
    localparam int TABLE_LEN = 24;

    localparam logic [LEN_W-1:0] FIRST_LEN_RESET  = 15'd6554;
    localparam logic [LEN_W-1:0] SECOND_LEN_RESET = 15'd4915;

    localparam logic REG_FIRST_LINK  = 1'b0;
    localparam logic REG_SECOND_LINK = 1'b1;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    localparam logic signed [CORDIC_W-1:0] GAIN_Q30 = 34'sd652032874;

    localparam logic signed [17:0] TRIG_POS_ONE = 18'sd16384;
    localparam logic signed [17:0] TRIG_NEG_ONE = -18'sd16384;
    localparam logic signed [17:0] COORD_MAX    = 18'sd32767;
    localparam logic signed [17:0] COORD_MIN    = -18'sd32768;

    localparam logic [31:0] ATAN_TURN32 [TABLE_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // atan(2^-idx) in 2^-abits turn units, rounded half up
    function automatic logic [31:0] atan_step(input int unsigned idx,
                                              input int unsigned abits);
        logic [32:0] s;
        s = {1'b0, ATAN_TURN32[idx]} + (33'd1 << (31 - abits));
        return 32'(s >> (32 - abits));
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [17:0] c;
        if (v > COORD_MAX)
            c = COORD_MAX;
        else if (v < COORD_MIN)
            c = COORD_MIN;
        else
            c = v;
        return c[15:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/pft_if.sv */
// ----------------------------------------------------------------------------
// pft_if
// Valid/ready channels: joint angle pair in, pose result out.
// ----------------------------------------------------------------------------
`default_nettype none

interface pft_joint_if;
    logic        valid;
    logic        ready;
    logic [15:0] base_joint_angle;
    logic [15:0] elbow_joint_angle;

    modport source (output valid, output base_joint_angle, output elbow_joint_angle,
                    input ready);
    modport sink   (input valid, input base_joint_angle, input elbow_joint_angle,
                    output ready);
endinterface

interface pft_pose_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] elbow_x;
    logic signed [15:0] elbow_y;
    logic signed [15:0] tip_x;
    logic signed [15:0] tip_y;
    logic signed [15:0] heading_cos;
    logic signed [15:0] heading_sin;

    modport source (output valid, output elbow_x, output elbow_y, output tip_x,
                    output tip_y, output heading_cos, output heading_sin,
                    input ready);
    modport sink   (input valid, input elbow_x, input elbow_y, input tip_x,
                    input tip_y, input heading_cos, input heading_sin,
                    output ready);
endinterface

`default_nettype wire

/* rtl/planar_two_link_forward_kinematics.sv */
// ----------------------------------------------------------------------------
// planar_two_link_forward_kinematics
// Two-link planar arm: elbow and tip position plus heading cos/sin.
// ----------------------------------------------------------------------------
// joints: valid/ready sink, one transfer per angle pair (binary angles).
// pose:   valid/ready source, one transfer per angle pair, in order.
// cfg:    write port, cfg_index 0 = first link length, 1 = second link
//         length, unsigned Q1.14; write only while the pipeline is empty.
// Stages: reduction, one stage per CORDIC iteration, quadrant map and
// rounding, link multiply, add and saturate.
// Throughput: one pair per cycle while pose is not stalled; two CORDIC pipelines (base angle and
// summed angle) run side by side, four multipliers in one stage.
// Stall: a stage holds only while it is full and its successor holds, so
// bubbles close up; joints.ready is low only when every stage holds an item.
// Reset: valid bits clear, link lengths return to 6554 and 4915.
// ----------------------------------------------------------------------------
`default_nettype none

module planar_two_link_forward_kinematics #(
    parameter int CORDIC_ITERATIONS = 16,
    parameter int ANGLE_BITS        = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    pft_joint_if.sink                        joints,
    pft_pose_if.source                       pose,
    input  wire logic                        cfg_we,
    input  wire logic                        cfg_index,
    input  wire logic [pft_pkg::LEN_W-1:0]   cfg_data
);

    localparam int CSTAGES = CORDIC_ITERATIONS + 2;
    localparam int DEPTH   = CSTAGES + 2;
    localparam int MUL     = CSTAGES;
    localparam int LAST    = CSTAGES + 1;

    logic [pft_pkg::LEN_W-1:0] first_len_reg;
    logic [pft_pkg::LEN_W-1:0] second_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_len_reg  <= pft_pkg::FIRST_LEN_RESET;
            second_len_reg <= pft_pkg::SECOND_LEN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pft_pkg::REG_FIRST_LINK:  first_len_reg  <= cfg_data;
                pft_pkg::REG_SECOND_LINK: second_len_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;
    logic [DEPTH-1:0] en;

    always_comb
    begin
        en[DEPTH-1] = !valid_reg[DEPTH-1] || pose.ready;
        for (int k = DEPTH - 2; k >= 0; k--)
            en[k] = !valid_reg[k] || en[k+1];
        valid_next = valid_reg;
        if (en[0])
            valid_next[0] = joints.valid;
        for (int k = 1; k < DEPTH; k++)
            if (en[k])
                valid_next[k] = valid_reg[k-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign joints.ready = en[0];

    logic [15:0]           angle_sum;
    logic [ANGLE_BITS-1:0] phase_base;
    logic [ANGLE_BITS-1:0] phase_sum;

    assign angle_sum = joints.base_joint_angle + joints.elbow_joint_angle;

    if (ANGLE_BITS > 16)
    begin : g_phase_up
        assign phase_base = {joints.base_joint_angle, {(ANGLE_BITS-16){1'b0}}};
        assign phase_sum  = {angle_sum, {(ANGLE_BITS-16){1'b0}}};
    end
    else if (ANGLE_BITS < 16)
    begin : g_phase_dn
        assign phase_base = joints.base_joint_angle[15 -: ANGLE_BITS];
        assign phase_sum  = angle_sum[15 -: ANGLE_BITS];
    end
    else
    begin : g_phase_eq
        assign phase_base = joints.base_joint_angle;
        assign phase_sum  = angle_sum;
    end

    logic signed [15:0] cos_base;
    logic signed [15:0] sin_base;
    logic signed [15:0] cos_sum;
    logic signed [15:0] sin_sum;

    pft_cordic #(
        .ITERATIONS (CORDIC_ITERATIONS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_cordic_base (
        .clk     (clk),
        .en      (en[CSTAGES-1:0]),
        .phase   (phase_base),
        .cos_q14 (cos_base),
        .sin_q14 (sin_base)
    );

    pft_cordic #(
        .ITERATIONS (CORDIC_ITERATIONS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_cordic_sum (
        .clk     (clk),
        .en      (en[CSTAGES-1:0]),
        .phase   (phase_sum),
        .cos_q14 (cos_sum),
        .sin_q14 (sin_sum)
    );

    logic signed [15:0] len1_s;
    logic signed [15:0] len2_s;
    logic signed [31:0] prod_ex_reg;
    logic signed [31:0] prod_ey_reg;
    logic signed [31:0] prod_tx_reg;
    logic signed [31:0] prod_ty_reg;
    logic signed [15:0] hcos_reg;
    logic signed [15:0] hsin_reg;

    assign len1_s = $signed({1'b0, first_len_reg});
    assign len2_s = $signed({1'b0, second_len_reg});

    always_ff @(posedge clk)
    begin
        if (en[MUL])
        begin
            prod_ex_reg <= len1_s * cos_base;
            prod_ey_reg <= len1_s * sin_base;
            prod_tx_reg <= len2_s * cos_sum;
            prod_ty_reg <= len2_s * sin_sum;
            hcos_reg    <= cos_sum;
            hsin_reg    <= sin_sum;
        end
    end

    logic signed [17:0] ex;
    logic signed [17:0] ey;
    logic signed [17:0] tx;
    logic signed [17:0] ty;

    assign ex = 18'((prod_ex_reg + 32'sd8192) >>> 14);
    assign ey = 18'((prod_ey_reg + 32'sd8192) >>> 14);
    assign tx = ex + 18'((prod_tx_reg + 32'sd8192) >>> 14);
    assign ty = ey + 18'((prod_ty_reg + 32'sd8192) >>> 14);

    logic signed [15:0] elbow_x_reg;
    logic signed [15:0] elbow_y_reg;
    logic signed [15:0] tip_x_reg;
    logic signed [15:0] tip_y_reg;
    logic signed [15:0] heading_cos_reg;
    logic signed [15:0] heading_sin_reg;

    always_ff @(posedge clk)
    begin
        if (en[LAST])
        begin
            elbow_x_reg     <= pft_pkg::sat16(ex);
            elbow_y_reg     <= pft_pkg::sat16(ey);
            tip_x_reg       <= pft_pkg::sat16(tx);
            tip_y_reg       <= pft_pkg::sat16(ty);
            heading_cos_reg <= hcos_reg;
            heading_sin_reg <= hsin_reg;
        end
    end

    assign pose.valid       = valid_reg[LAST];
    assign pose.elbow_x     = elbow_x_reg;
    assign pose.elbow_y     = elbow_y_reg;
    assign pose.tip_x       = tip_x_reg;
    assign pose.tip_y       = tip_y_reg;
    assign pose.heading_cos = heading_cos_reg;
    assign pose.heading_sin = heading_sin_reg;

`ifndef ASSERT_OFF
    a_ready_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !joints.ready |-> (&valid_reg))
        else $error("input stalled with an empty stage");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (joints.valid && joints.ready) |=> valid_reg[0])
        else $error("accepted pair missing from first stage");

    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        pose.valid |-> (pose.heading_cos <= 16'sd16384 && pose.heading_cos >= -16'sd16384
                        && pose.heading_sin <= 16'sd16384
                        && pose.heading_sin >= -16'sd16384))
        else $error("heading out of range");

    a_cfg_first: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && cfg_index == pft_pkg::REG_FIRST_LINK) |=> first_len_reg == $past(cfg_data))
        else $error("first link length write lost");

    a_stall_holds_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[LAST] && !pose.ready) |=> valid_reg[LAST] && $stable(tip_x_reg))
        else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

/* rtl/pft_cordic.sv */
// ----------------------------------------------------------------------------
// pft_cordic
// Pipelined rotation-mode CORDIC: quadrant reduction, one stage per
// iteration, then quadrant mapping with rounding and clamping to Q1.14.
// ----------------------------------------------------------------------------
`default_nettype none

module pft_cordic #(
    parameter int ITERATIONS = 16,
    parameter int ANGLE_BITS = 16
) (
    input  wire logic                    clk,
    input  wire logic [ITERATIONS+1:0]   en,
    input  wire logic [ANGLE_BITS-1:0]   phase,
    output logic signed [15:0]           cos_q14,
    output logic signed [15:0]           sin_q14
);

    localparam int XW = pft_pkg::CORDIC_W;
    localparam int ZW = ANGLE_BITS + 1;
    localparam logic [ANGLE_BITS-1:0] EIGHTH = ANGLE_BITS'(1) << (ANGLE_BITS - 3);

    logic signed [XW-1:0] x_reg [ITERATIONS+1];
    logic signed [XW-1:0] y_reg [ITERATIONS+1];
    logic signed [ZW-1:0] z_reg [ITERATIONS+1];
    logic [1:0]           q_reg [ITERATIONS+1];

    logic [ANGLE_BITS-1:0] shifted;
    logic signed [ZW-1:0]  z_init;

    assign shifted = phase + EIGHTH;
    assign z_init  = $signed({3'b000, shifted[ANGLE_BITS-3:0]}) - $signed(ZW'(EIGHTH));

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            x_reg[0] <= pft_pkg::GAIN_Q30;
            y_reg[0] <= '0;
            z_reg[0] <= z_init;
            q_reg[0] <= shifted[ANGLE_BITS-1 -: 2];
        end
    end

    for (genvar i = 0; i < ITERATIONS; i++)
    begin : g_iter
        localparam logic signed [ZW-1:0] ATAN_I = ZW'(pft_pkg::atan_step(i, ANGLE_BITS));
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;

        assign dx = x_reg[i] >>> i;
        assign dy = y_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            if (en[i+1])
            begin
                if (!z_reg[i][ZW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - dy;
                    y_reg[i+1] <= y_reg[i] + dx;
                    z_reg[i+1] <= z_reg[i] - ATAN_I;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + dy;
                    y_reg[i+1] <= y_reg[i] - dx;
                    z_reg[i+1] <= z_reg[i] + ATAN_I;
                end
                q_reg[i+1] <= q_reg[i];
            end
        end
    end

    logic signed [XW-1:0] c_full;
    logic signed [XW-1:0] s_full;
    logic signed [17:0]   c_rnd;
    logic signed [17:0]   s_rnd;
    logic signed [17:0]   c_clamp;
    logic signed [17:0]   s_clamp;
    logic signed [15:0]   cos_reg;
    logic signed [15:0]   sin_reg;

    always_comb
    begin
        case (q_reg[ITERATIONS])
            pft_pkg::QUAD_0:
            begin
                c_full = x_reg[ITERATIONS];
                s_full = y_reg[ITERATIONS];
            end
            pft_pkg::QUAD_1:
            begin
                c_full = -y_reg[ITERATIONS];
                s_full = x_reg[ITERATIONS];
            end
            pft_pkg::QUAD_2:
            begin
                c_full = -x_reg[ITERATIONS];
                s_full = -y_reg[ITERATIONS];
            end
            default:
            begin
                c_full = y_reg[ITERATIONS];
                s_full = -x_reg[ITERATIONS];
            end
        endcase
        c_rnd = 18'((c_full + XW'(32768)) >>> 16);
        s_rnd = 18'((s_full + XW'(32768)) >>> 16);
        if (c_rnd > pft_pkg::TRIG_POS_ONE)
            c_clamp = pft_pkg::TRIG_POS_ONE;
        else if (c_rnd < pft_pkg::TRIG_NEG_ONE)
            c_clamp = pft_pkg::TRIG_NEG_ONE;
        else
            c_clamp = c_rnd;
        if (s_rnd > pft_pkg::TRIG_POS_ONE)
            s_clamp = pft_pkg::TRIG_POS_ONE;
        else if (s_rnd < pft_pkg::TRIG_NEG_ONE)
            s_clamp = pft_pkg::TRIG_NEG_ONE;
        else
            s_clamp = s_rnd;
    end

    always_ff @(posedge clk)
    begin
        if (en[ITERATIONS+1])
        begin
            cos_reg <= c_clamp[15:0];
            sin_reg <= s_clamp[15:0];
        end
    end

    assign cos_q14 = cos_reg;
    assign sin_q14 = sin_reg;

endmodule

`default_nettype wire
